@@ design/dcotd_pkg.sv @@
`timescale 1ns / 1ps
package dcotd_pkg;

	localparam int QueueDepthDefault = 4;

	localparam logic [2:0] StOk        = 3'd0;
	localparam logic [2:0] StBadFormat = 3'd1;
	localparam logic [2:0] StNegName   = 3'd2;
	localparam logic [2:0] StBadPtr    = 3'd3;
	localparam logic [2:0] StEarlyEnd  = 3'd4;
	localparam logic [2:0] StTrailing  = 3'd5;

	localparam logic [31:0] FormatWord = 32'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic        item_kind;
		logic [63:0] entry_id;
		logic [63:0] entry_offset;
		logic [2:0]  status_code;
		logic        final_item;
	} out_item_t;

	typedef struct packed {
		logic        is_status;
		logic        final_item;
		logic [63:0] entry_id;
		logic [63:0] raw;
		logic [3:0]  hi_nibble;
		logic [30:0] pointer_size;
		logic [2:0]  status_code;
	} cmd_t;

	function automatic logic [3:0] kind_len(input logic [3:0] k);
		logic [3:0] r;
		unique case (k)
			4'd0: r = 4'd8;
			4'd2, 4'd3: r = 4'd1;
			4'd4, 4'd5, 4'd6: r = 4'd2;
			4'd7: r = 4'd4;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] kind_apply(input logic [3:0] k, input logic [63:0] p,
			input logic [63:0] v);
		logic [63:0] r;
		unique case (k)
			4'd0, 4'd6, 4'd7: r = v;
			4'd1: r = p + 64'd1;
			4'd2, 4'd4: r = p + v;
			4'd3, 4'd5: r = p - v;
			default: r = p;
		endcase
		return r;
	endfunction

endpackage

@@ design/dcotd_front.sv @@
`timescale 1ns / 1ps
module dcotd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  dcotd_pkg::in_item_t byte_data,
	output logic              push,
	output dcotd_pkg::cmd_t   push_cmd,
	input  logic              queue_full
);
	import dcotd_pkg::*;

	localparam logic [3:0] PH_FORMAT  = 4'd0;
	localparam logic [3:0] PH_SKIP    = 4'd1;
	localparam logic [3:0] PH_NAMELEN = 4'd2;
	localparam logic [3:0] PH_NAME    = 4'd3;
	localparam logic [3:0] PH_PTRSIZE = 4'd4;
	localparam logic [3:0] PH_COUNT   = 4'd5;
	localparam logic [3:0] PH_CTRL    = 4'd6;
	localparam logic [3:0] PH_IDVAL   = 4'd7;
	localparam logic [3:0] PH_OFFVAL  = 4'd8;
	localparam logic [3:0] PH_TRAIL   = 4'd9;
	localparam logic [3:0] PH_DRAIN   = 4'd10;

	logic [3:0]  phase_q, n_phase;
	logic [2:0]  bidx_q, n_bidx;
	logic [63:0] gather_q, n_gather;
	logic [1:0]  hws_q, n_hws;
	logic [30:0] namel_q, n_namel;
	logic [30:0] ps_q, n_ps;
	logic [30:0] recs_q, n_recs;
	logic [7:0]  ctrl_q, n_ctrl;
	logic [63:0] prev_id_q, n_prev_id;
	logic [63:0] pend_id_q, n_pend_id;
	logic [2:0]  err_q, n_err;
	logic        pend_st_q, n_pend_st;
	logic [2:0]  pend_code_q, n_pend_code;

	logic        accept;
	logic [63:0] gw;
	logic [3:0]  bidx_inc;
	logic [7:0]  b;
	logic        push_entry;
	logic [63:0] e_raw;
	logic [2:0]  st;

	assign byte_stall = pend_st_q | queue_full;
	assign accept     = byte_valid & ~byte_stall;
	assign b          = byte_data.data_byte;
	assign gw         = gather_q | ({56'd0, b} << {bidx_q, 3'b000});
	assign bidx_inc   = {1'b0, bidx_q} + 4'd1;

	always_comb begin
		n_phase = phase_q; n_bidx = bidx_q; n_gather = gather_q; n_hws = hws_q;
		n_namel = namel_q; n_ps = ps_q; n_recs = recs_q; n_ctrl = ctrl_q;
		n_prev_id = prev_id_q; n_pend_id = pend_id_q; n_err = err_q;
		n_pend_st = pend_st_q; n_pend_code = pend_code_q;
		push_entry = 1'b0;
		e_raw = 64'd0;
		st = StOk;
		push = 1'b0;
		push_cmd = '0;
		if (pend_st_q) begin
			if (!queue_full) begin
				push = 1'b1;
				push_cmd.is_status = 1'b1;
				push_cmd.final_item = 1'b1;
				push_cmd.status_code = pend_code_q;
				n_pend_st = 1'b0;
			end
		end else if (accept) begin
			unique case (phase_q)
				PH_FORMAT, PH_SKIP, PH_NAMELEN, PH_PTRSIZE, PH_COUNT: begin
					if (bidx_q == 3'd3) begin
						n_bidx = 3'd0;
						n_gather = 64'd0;
						unique case (phase_q)
							PH_FORMAT: begin
								if (gw[31:0] != FormatWord) begin
									n_err = StBadFormat; n_phase = PH_DRAIN;
								end else n_phase = PH_SKIP;
							end
							PH_SKIP: begin
								if (hws_q == 2'd3) begin
									n_hws = 2'd0; n_phase = PH_NAMELEN;
								end else n_hws = hws_q + 2'd1;
							end
							PH_NAMELEN: begin
								if (gw[31]) begin
									n_err = StNegName; n_phase = PH_DRAIN;
								end else begin
									n_namel = gw[30:0];
									n_phase = (gw[30:0] != 31'd0) ? PH_NAME : PH_PTRSIZE;
								end
							end
							PH_PTRSIZE: begin
								n_ps = gw[31] ? 31'd0 : gw[30:0];
								n_phase = PH_COUNT;
							end
							default: begin
								if (ps_q == 31'd0 || gw[31]) begin
									n_err = StBadPtr; n_phase = PH_DRAIN;
								end else begin
									n_recs = gw[30:0];
									n_prev_id = 64'd0;
									n_phase = (gw[30:0] != 31'd0) ? PH_CTRL : PH_TRAIL;
								end
							end
						endcase
					end else begin
						n_bidx = bidx_inc[2:0];
						n_gather = gw;
					end
				end
				PH_NAME: begin
					n_namel = namel_q - 31'd1;
					if (namel_q == 31'd1) n_phase = PH_PTRSIZE;
				end
				PH_CTRL: begin
					n_ctrl = b;
					n_recs = recs_q - 31'd1;
					n_gather = 64'd0;
					n_bidx = 3'd0;
					if (kind_len(b[3:0]) == 4'd0) begin
						n_pend_id = kind_apply(b[3:0], prev_id_q, 64'd0);
						if (kind_len({1'b0, b[6:4]}) == 4'd0) push_entry = 1'b1;
						else n_phase = PH_OFFVAL;
					end else n_phase = PH_IDVAL;
				end
				PH_IDVAL: begin
					if (bidx_inc >= kind_len(ctrl_q[3:0])) begin
						n_pend_id = kind_apply(ctrl_q[3:0], prev_id_q, gw);
						n_gather = 64'd0;
						n_bidx = 3'd0;
						if (kind_len({1'b0, ctrl_q[6:4]}) == 4'd0) push_entry = 1'b1;
						else n_phase = PH_OFFVAL;
					end else begin
						n_gather = gw;
						n_bidx = bidx_inc[2:0];
					end
				end
				PH_OFFVAL: begin
					if (bidx_inc >= kind_len({1'b0, ctrl_q[6:4]})) begin
						n_gather = 64'd0;
						n_bidx = 3'd0;
						e_raw = gw;
						push_entry = 1'b1;
					end else begin
						n_gather = gw;
						n_bidx = bidx_inc[2:0];
					end
				end
				PH_TRAIL: begin
					n_err = StTrailing; n_phase = PH_DRAIN;
				end
				default: ;
			endcase
			if (push_entry) begin
				push = 1'b1;
				push_cmd.entry_id = n_pend_id;
				push_cmd.raw = e_raw;
				push_cmd.hi_nibble = n_ctrl[7:4];
				push_cmd.pointer_size = ps_q;
				push_cmd.final_item = ~byte_data.end_of_file;
				n_prev_id = n_pend_id;
				n_phase = (n_recs != 31'd0) ? PH_CTRL : PH_TRAIL;
			end
			if (byte_data.end_of_file) begin
				st = (n_err != StOk) ? n_err : ((n_phase == PH_TRAIL) ? StOk : StEarlyEnd);
				if (push_entry) begin
					n_pend_st = 1'b1;
					n_pend_code = st;
				end else begin
					push = 1'b1;
					push_cmd.is_status = 1'b1;
					push_cmd.final_item = 1'b1;
					push_cmd.status_code = st;
				end
				n_phase = PH_FORMAT; n_bidx = 3'd0; n_gather = 64'd0; n_hws = 2'd0;
				n_namel = 31'd0; n_ps = 31'd0; n_recs = 31'd0; n_ctrl = 8'd0;
				n_prev_id = 64'd0; n_pend_id = 64'd0; n_err = StOk;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FORMAT; bidx_q <= 3'd0; gather_q <= 64'd0; hws_q <= 2'd0;
			namel_q <= 31'd0; ps_q <= 31'd0; recs_q <= 31'd0; ctrl_q <= 8'd0;
			prev_id_q <= 64'd0; pend_id_q <= 64'd0; err_q <= StOk;
			pend_st_q <= 1'b0; pend_code_q <= StOk;
		end else begin
			phase_q <= n_phase; bidx_q <= n_bidx; gather_q <= n_gather; hws_q <= n_hws;
			namel_q <= n_namel; ps_q <= n_ps; recs_q <= n_recs; ctrl_q <= n_ctrl;
			prev_id_q <= n_prev_id; pend_id_q <= n_pend_id; err_q <= n_err;
			pend_st_q <= n_pend_st; pend_code_q <= n_pend_code;
		end
	end

endmodule

@@ design/dcotd_queue.sv @@
`timescale 1ns / 1ps
module dcotd_queue #(
	parameter int Depth = dcotd_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcotd_pkg::cmd_t push_cmd,
	output logic            full,
	output logic            head_valid,
	output dcotd_pkg::cmd_t head_cmd,
	input  logic            pop
);
	import dcotd_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= nxt(wr_q);
			if (pop && head_valid) rd_q <= nxt(rd_q);
			cnt_q <= cnt_q + CntW'(push && !full) - CntW'(pop && head_valid);
		end
	end

endmodule

@@ design/dcotd_back.sv @@
`timescale 1ns / 1ps
module dcotd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  dcotd_pkg::cmd_t    head_cmd,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output dcotd_pkg::out_item_t result_data
);
	import dcotd_pkg::*;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_DIV   = 3'd1;
	localparam logic [2:0] B_APPLY = 3'd2;
	localparam logic [2:0] B_MLO   = 3'd3;
	localparam logic [2:0] B_MHI   = 3'd4;
	localparam logic [2:0] B_SUM   = 3'd5;
	localparam logic [2:0] B_OUT   = 3'd6;

	logic [2:0]  state_q;
	cmd_t        cmd_q;
	logic        scaled_q;
	logic [63:0] prev_off_q;
	logic [63:0] quo_q;
	logic [30:0] rem_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [62:0] mlo_q;
	logic [31:0] mhi_q;
	out_item_t   res_q;

	logic [31:0] rem_sh;
	logic        ge;
	logic [61:0] mhi_full;
	logic [63:0] off_sum;

	assign pop          = (state_q == B_IDLE) & head_valid;
	assign result_valid = (state_q == B_OUT);
	assign result_data  = res_q;
	assign rem_sh       = {rem_q, quo_q[63]};
	assign ge           = rem_sh >= {1'b0, cmd_q.pointer_size};
	assign mhi_full     = acc_q[63:32] * cmd_q.pointer_size;
	assign off_sum      = {1'b0, mlo_q} + {mhi_q, 32'd0};

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (head_valid) begin
				cmd_q <= head_cmd;
				scaled_q <= head_cmd.hi_nibble[3] && (head_cmd.pointer_size != 31'd0);
				quo_q <= prev_off_q;
				rem_q <= 31'd0;
				cnt_q <= 6'd0;
				res_q.item_kind <= head_cmd.is_status;
				res_q.entry_id <= head_cmd.is_status ? 64'd0 : head_cmd.entry_id;
				res_q.entry_offset <= 64'd0;
				res_q.status_code <= head_cmd.is_status ? head_cmd.status_code : StOk;
				res_q.final_item <= head_cmd.final_item;
			end
			B_DIV: begin
				rem_q <= ge ? 31'(rem_sh - {1'b0, cmd_q.pointer_size}) : rem_sh[30:0];
				quo_q <= {quo_q[62:0], ge};
				cnt_q <= cnt_q + 6'd1;
			end
			B_APPLY: begin
				acc_q <= kind_apply({1'b0, cmd_q.hi_nibble[2:0]}, quo_q, cmd_q.raw);
				if (!scaled_q)
					res_q.entry_offset <= kind_apply({1'b0, cmd_q.hi_nibble[2:0]}, quo_q,
						cmd_q.raw);
			end
			B_MLO: mlo_q <= acc_q[31:0] * cmd_q.pointer_size;
			B_MHI: mhi_q <= mhi_full[31:0];
			B_SUM: res_q.entry_offset <= off_sum;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			prev_off_q <= 64'd0;
		end else begin
			unique case (state_q)
				B_IDLE: if (head_valid) begin
					if (head_cmd.is_status) begin
						prev_off_q <= 64'd0;
						state_q <= B_OUT;
					end else if (head_cmd.hi_nibble[3] && head_cmd.pointer_size != 31'd0)
						state_q <= B_DIV;
					else state_q <= B_APPLY;
				end
				B_DIV: if (cnt_q == 6'd63) state_q <= B_APPLY;
				B_APPLY: begin
					if (scaled_q) state_q <= B_MLO;
					else begin
						prev_off_q <= kind_apply({1'b0, cmd_q.hi_nibble[2:0]}, quo_q,
							cmd_q.raw);
						state_q <= B_OUT;
					end
				end
				B_MLO: state_q <= B_MHI;
				B_MHI: state_q <= B_SUM;
				B_SUM: begin
					prev_off_q <= off_sum;
					state_q <= B_OUT;
				end
				B_OUT: if (!result_stall) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (cmd_q.pointer_size != 31'd0))
		else $error("divide with zero pointer size");
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && res_q.item_kind) |-> res_q.final_item)
		else $error("status transaction not final");
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_cmd.is_status) |=> (prev_off_q == 64'd0))
		else $error("offset history not cleared at status");

endmodule

@@ design/delta_coded_offset_table_decoder.sv @@
`timescale 1ns / 1ps
// channel  valid         stall         payload
// input    byte_valid    byte_stall    byte_data   (data_byte, end_of_file)
// output   result_valid  result_stall  result_data (item_kind .. final_item)
// the front takes one byte a cycle while the input is not stalled; a byte that completes a
// record and ends the file holds its status back, stalling the input until it is queued
// the back runs an unscaled entry through its apply step, and a scaled one through a 64-step
// restoring divide, the apply step and a two-part multiply, then outputs each transaction
// reset clears both parts and the queue; no clearing pass
// the input stalls while the queue is full or a held status waits for room
module delta_coded_offset_table_decoder #(
	parameter int QueueDepth = dcotd_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  dcotd_pkg::in_item_t  byte_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output dcotd_pkg::out_item_t result_data
);
	import dcotd_pkg::*;

	logic push, full, head_valid, pop;
	cmd_t push_cmd, head_cmd;

	dcotd_front u_front (
		.clk, .arst_n, .byte_valid, .byte_stall, .byte_data,
		.push, .push_cmd, .queue_full(full)
	);

	dcotd_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push, .push_cmd, .full, .head_valid, .head_cmd, .pop
	);

	dcotd_back u_back (
		.clk, .arst_n, .head_valid, .head_cmd, .pop,
		.result_valid, .result_stall, .result_data
	);

endmodule
